>>> sv/hst_pkg.sv
// Shared widths, register codes, reset values and stage payload types of the heater soak timer.
package hst_pkg;

	// field widths
	localparam int TempW   = 13;
	localparam int TargetW = 8;
	localparam int ZoneW   = 16;
	localparam int TimeW   = 32;
	localparam int RemW    = 15;

	// register widths
	localparam int WinW   = 6;
	localparam int MinW   = 8;
	localparam int BaseW  = 10;
	localparam int SlopeW = 6;

	// configuration port
	localparam int CfgIdxW  = 3;
	localparam int CfgDataW = 10;

	localparam logic [CfgIdxW-1:0] REG_NEAR_WINDOW = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MIN_TARGET  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_BASE_SOAK   = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_SOAK_SLOPE  = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ZONE_CHECK  = 3'd4;

	localparam logic [WinW-1:0]   NEAR_WINDOW_RST = 6'd15;
	localparam logic [MinW-1:0]   MIN_TARGET_RST  = 8'd60;
	localparam logic [BaseW-1:0]  BASE_SOAK_RST   = 10'd180;
	localparam logic [SlopeW-1:0] SOAK_SLOPE_RST  = 6'd14;
	localparam logic              ZONE_CHECK_RST  = 1'b1;

	localparam int ZONE_BITS_DEF = 16;

	// temperature difference in 1/16 degree: -8176 .. 4095
	localparam int DiffW = TempW + 2;

	// required soak: at most 1023 + 255 * 63 = 17088 s, 17088000 ms
	localparam int ReqSW  = 15;
	localparam int ReqMsW = 25;
	localparam int MsPerS = 1000;

	// remaining time in ms, signed: req_ms minus a signed 32-bit elapsed time
	localparam int LeftW = TimeW + 2;

	localparam int RemMax = (1 << RemW) - 1;
	// first remainder in ms that saturates the seconds output
	localparam logic [ReqMsW-1:0] SAT_LEFT_MS = ReqMsW'((RemMax + 1) * MsPerS);

	// x / 1000 = (x >> 3) / 125, and y / 125 = (y * RECIP) >> RecipShift for y < 2^22
	localparam int QuotInW    = ReqMsW - 3;
	localparam int RecipW     = 23;
	localparam int RecipShift = 29;
	localparam logic [RecipW-1:0] RECIP_125 = 23'd4294968;

	typedef struct packed {
		logic [WinW-1:0]   near_window_deg;
		logic [MinW-1:0]   min_soak_target;
		logic [BaseW-1:0]  base_soak_s;
		logic [SlopeW-1:0] soak_per_degree_s;
		logic              zone_check_enable;
	} cfg_t;

	// front end to soak tracker
	typedef struct packed {
		logic              ok;
		logic [ReqMsW-1:0] req_ms;
		logic [TimeW-1:0]  now_ms;
	} front_t;

	// soak tracker to output stage
	typedef struct packed {
		logic              soak_allowed;
		logic              soak_done;
		logic              rem_needed;
		logic              rem_sat;
		logic [ReqMsW-1:0] left_ms;
	} track_t;

endpackage

>>> sv/hst_if.sv
// Valid/ready channel interfaces for samples and results.
interface hst_sample_if import hst_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [TempW-1:0]   bed_temp_q4;
	logic        [TargetW-1:0] target_temp;
	logic        [ZoneW-1:0]   zone_mask;
	logic        [TimeW-1:0]   now_ms;

	modport source(output valid, output bed_temp_q4, output target_temp, output zone_mask,
		output now_ms, input ready);
	modport sink(input valid, input bed_temp_q4, input target_temp, input zone_mask,
		input now_ms, output ready);
endinterface

interface hst_result_if import hst_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            soak_allowed;
	logic            soak_done;
	logic [RemW-1:0] secs_left;

	modport source(output valid, output soak_allowed, output soak_done, output secs_left,
		input ready);
	modport sink(input valid, input soak_allowed, input soak_done, input secs_left,
		output ready);
endinterface

>>> sv/heater_soak_timer_core.sv
// Heater soak timer top level: configuration registers and the five-stage sample pipeline.
// Takes one sample per clock unless the output stalls, and returns one result per sample, in
// order. A result is valid in the output register after the five pipeline registers of a chained
// valid/ready path; any empty stage takes a new sample even while the output waits. A sample is
// near when the target is nonzero and the temperature lies strictly inside the window; a zone
// mask change (when checked) or a far sample clears the soak. The required soak is zero below the
// minimum target, else base plus slope times the degrees above it. Done is sticky once less than
// one second remains; remaining seconds saturate at 32767. The user must write registers through
// write_en/reg_index/write_data only while no sample is in flight; the block does not enforce it.
module heater_soak_timer_core import hst_pkg::*; #(
	parameter int ZONE_BITS = ZONE_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                write_en,
	input  logic [CfgIdxW-1:0]  reg_index,
	input  logic [CfgDataW-1:0] write_data,
	hst_sample_if.sink          sample,
	hst_result_if.source        result
);

	cfg_t   cfg_q;

	logic   front_valid, front_ready;
	front_t front_data;
	logic   track_valid, track_ready;
	track_t track_data;

	// configuration registers; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.near_window_deg   <= NEAR_WINDOW_RST;
			cfg_q.min_soak_target   <= MIN_TARGET_RST;
			cfg_q.base_soak_s       <= BASE_SOAK_RST;
			cfg_q.soak_per_degree_s <= SOAK_SLOPE_RST;
			cfg_q.zone_check_enable <= ZONE_CHECK_RST;
		end else if (write_en) begin
			unique case (reg_index)
				REG_NEAR_WINDOW: cfg_q.near_window_deg   <= write_data[WinW-1:0];
				REG_MIN_TARGET:  cfg_q.min_soak_target   <= write_data[MinW-1:0];
				REG_BASE_SOAK:   cfg_q.base_soak_s       <= write_data[BaseW-1:0];
				REG_SOAK_SLOPE:  cfg_q.soak_per_degree_s <= write_data[SlopeW-1:0];
				REG_ZONE_CHECK:  cfg_q.zone_check_enable <= write_data[0];
				default: ;
			endcase
		end
	end

	// stages 1-3: sample register, window test, required soak in ms
	hst_front #(
		.ZONE_BITS(ZONE_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.sample     (sample),
		.front_valid(front_valid),
		.front_ready(front_ready),
		.front_data (front_data)
	);

	// stage 4: start time and sticky done, the only stage holding soak state
	hst_track u_track (
		.clk        (clk),
		.arst_n     (arst_n),
		.front_valid(front_valid),
		.front_ready(front_ready),
		.front_data (front_data),
		.track_valid(track_valid),
		.track_ready(track_ready),
		.track_data (track_data)
	);

	// stage 5: seconds conversion into the output register
	hst_out u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.track_valid(track_valid),
		.track_ready(track_ready),
		.track_data (track_data),
		.result     (result)
	);

	// done only ever reported inside an allowed soak
	a_done_needs_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.soak_done |-> result.soak_allowed)
		else $error("soak_done without soak_allowed");

	// a finished or broken soak shows no remaining time
	a_rem_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && (result.soak_done || !result.soak_allowed) |-> result.secs_left == '0)
		else $error("secs_left nonzero when done or not allowed");

	// saturation and remaining time only on an open, unfinished soak
	a_track_flags: assert property (@(posedge clk) disable iff (!arst_n)
		track_valid && (track_data.rem_sat || track_data.rem_needed) |->
			track_data.rem_needed && track_data.soak_allowed && !track_data.soak_done)
		else $error("inconsistent tracker flags");

	// a stalled result stays put in the output register
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.secs_left))
		else $error("output stage changed while stalled");

endmodule

>>> sv/hst_front.sv
// Input register, zone change check, temperature window and required soak time stages.
module hst_front import hst_pkg::*; #(
	parameter int ZONE_BITS = ZONE_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  cfg_t       cfg,
	hst_sample_if.sink sample,
	output logic       front_valid,
	input  logic       front_ready,
	output front_t     front_data
);

	localparam int CmpBits = (ZONE_BITS < ZoneW) ? ZONE_BITS : ZoneW;

	logic valid_s1, valid_s2, valid_s3;
	logic rdy_s1, rdy_s2, rdy_s3;

	logic signed [TempW-1:0] temp_s1;
	logic [TargetW-1:0]      target_s1;
	logic [TimeW-1:0]        now_s1, now_s2, now_s3;
	logic                    changed_s1;
	logic                    ok_s2, ok_s3;
	logic [ReqSW-1:0]        req_s_s2;
	logic [ReqMsW-1:0]       req_ms_s3;
	logic [CmpBits-1:0]      last_mask_q;

	logic signed [DiffW-1:0] diff;
	logic [DiffW-1:0]        abs_diff;
	logic                    near;
	logic [TargetW-1:0]      over_min;
	logic [ReqSW-1:0]        req_s;
	logic                    take;

	assign rdy_s3       = !valid_s3 || front_ready;
	assign rdy_s2       = !valid_s2 || rdy_s3;
	assign rdy_s1       = !valid_s1 || rdy_s2;
	assign sample.ready = rdy_s1;
	assign take         = sample.valid && rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			last_mask_q <= '0;
		end else begin
			if (rdy_s1) valid_s1 <= sample.valid;
			if (rdy_s2) valid_s2 <= valid_s1;
			if (rdy_s3) valid_s3 <= valid_s2;
			// the mask is tracked whether or not the check is enabled
			if (take) last_mask_q <= sample.zone_mask[CmpBits-1:0];
		end
	end

	// window test in 1/16 degree; required soak in whole seconds
	always_comb begin
		diff     = DiffW'(temp_s1) - DiffW'({target_s1, 4'b0000});
		abs_diff = diff[DiffW-1] ? DiffW'(-diff) : DiffW'(diff);
		near     = (target_s1 != '0) && (abs_diff < DiffW'({cfg.near_window_deg, 4'b0000}));
		over_min = target_s1 - cfg.min_soak_target;
		if (target_s1 < cfg.min_soak_target) begin
			req_s = '0;
		end else begin
			req_s = ReqSW'(cfg.base_soak_s) + ReqSW'(over_min) * ReqSW'(cfg.soak_per_degree_s);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			temp_s1    <= sample.bed_temp_q4;
			target_s1  <= sample.target_temp;
			now_s1     <= sample.now_ms;
			changed_s1 <= (sample.zone_mask[CmpBits-1:0] != last_mask_q) && cfg.zone_check_enable;
		end
		if (valid_s1 && rdy_s2) begin
			ok_s2    <= near && !changed_s1;
			req_s_s2 <= req_s;
			now_s2   <= now_s1;
		end
		if (valid_s2 && rdy_s3) begin
			ok_s3     <= ok_s2;
			req_ms_s3 <= ReqMsW'(req_s_s2) * ReqMsW'(MsPerS);
			now_s3    <= now_s2;
		end
	end

	assign front_valid       = valid_s3;
	assign front_data.ok     = ok_s3;
	assign front_data.req_ms = req_ms_s3;
	assign front_data.now_ms = now_s3;

endmodule

>>> sv/hst_track.sv
// Soak state: start time, sticky done flag and remaining time in ms.
module hst_track import hst_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   front_valid,
	output logic   front_ready,
	input  front_t front_data,
	output logic   track_valid,
	input  logic   track_ready,
	output track_t track_data
);

	logic             valid_s4;
	logic [TimeW-1:0] start_q;
	logic             start_valid_q;
	logic             done_q;
	track_t           data_s4;

	logic [TimeW-1:0]        elapsed;
	logic signed [LeftW-1:0] left;
	logic                    under_1s;
	logic                    sat;
	logic                    fire;

	assign front_ready = !valid_s4 || track_ready;
	assign fire        = front_valid && front_ready;

	// elapsed is zero on the sample that opens the soak
	always_comb begin
		elapsed  = start_valid_q ? (front_data.now_ms - start_q) : '0;
		left     = LeftW'(front_data.req_ms) - LeftW'($signed(elapsed));
		under_1s = left < $signed(LeftW'(MsPerS));
		sat      = left >= $signed(LeftW'(SAT_LEFT_MS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4      <= 1'b0;
			start_q       <= '0;
			start_valid_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			if (front_ready) valid_s4 <= front_valid;
			if (fire) begin
				if (front_data.ok) begin
					if (!start_valid_q) begin
						start_q       <= front_data.now_ms;
						start_valid_q <= 1'b1;
					end
					if (!done_q && under_1s) done_q <= 1'b1;
				end else begin
					start_q       <= '0;
					start_valid_q <= 1'b0;
					done_q        <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			data_s4.soak_allowed <= front_data.ok;
			data_s4.soak_done    <= front_data.ok && (done_q || under_1s);
			data_s4.rem_needed   <= front_data.ok && !done_q && !under_1s;
			data_s4.rem_sat      <= front_data.ok && !done_q && !under_1s && sat;
			data_s4.left_ms      <= left[ReqMsW-1:0];
		end
	end

	assign track_valid = valid_s4;
	assign track_data  = data_s4;

endmodule

>>> sv/hst_out.sv
// Output register: ms to whole seconds by reciprocal multiply, with saturation.
module hst_out import hst_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          track_valid,
	output logic          track_ready,
	input  track_t        track_data,
	hst_result_if.source  result
);

	logic            valid_s5;
	logic            allowed_s5;
	logic            done_s5;
	logic [RemW-1:0] rem_s5;

	logic [QuotInW-1:0]        quot_in;
	logic [QuotInW+RecipW-1:0] prod;
	logic [RemW-1:0]           secs;
	logic                      fire;

	assign track_ready = !valid_s5 || result.ready;
	assign fire        = track_valid && track_ready;

	// only unsaturated remainders reach the quotient, so it fits RemW bits
	always_comb begin
		quot_in = track_data.left_ms[ReqMsW-1:3];
		prod    = (QuotInW+RecipW)'(quot_in) * (QuotInW+RecipW)'(RECIP_125);
		secs    = prod[RecipShift +: RemW];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else if (track_ready) begin
			valid_s5 <= track_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			allowed_s5 <= track_data.soak_allowed;
			done_s5    <= track_data.soak_done;
			if (!track_data.rem_needed) begin
				rem_s5 <= '0;
			end else if (track_data.rem_sat) begin
				rem_s5 <= RemW'(RemMax);
			end else begin
				rem_s5 <= secs;
			end
		end
	end

	assign result.valid        = valid_s5;
	assign result.soak_allowed = allowed_s5;
	assign result.soak_done    = done_s5;
	assign result.secs_left    = rem_s5;

endmodule

>>> tb/heater_soak_timer_core_test.sv
// Self-checking testbench for the heater soak timer core: directed, register, stall and random soak runs.
module heater_soak_timer_core_test import hst_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 2;
	localparam int RESET_CYCLES = 5;
	localparam int PIPE_SETTLE  = 8;    // pipeline depth plus margin before a register write
	localparam int DRAIN_CYCLES = 10;
	localparam int STALL_LIMIT  = 2000; // cycles with no transfer on either channel
	localparam int HOLD_CYCLES  = 60;   // long result stall that fills the pipeline
	localparam int IDLE_PCT     = 8;
	localparam int ITEM_GOAL    = 650;

	// one temperature sample as sent on the input channel
	typedef struct packed {
		logic signed [TempW-1:0] bed_temp;
		logic [TargetW-1:0]      target;
		logic [ZoneW-1:0]        zones;
		logic [TimeW-1:0]        stamp_ms;
	} soak_sample_t;

	// one soak status as returned on the result channel
	typedef struct packed {
		logic            allowed;
		logic            done;
		logic [RemW-1:0] remaining;
	} soak_status_t;

	logic clk;
	logic arst_n;
	logic write_en;
	logic [CfgIdxW-1:0]  reg_index;
	logic [CfgDataW-1:0] write_data;

	hst_sample_if sample_ch();
	hst_result_if result_ch();

	heater_soak_timer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.write_en(write_en),
		.reg_index(reg_index),
		.write_data(write_data),
		.sample(sample_ch),
		.result(result_ch)
	);

	// shadow registers and soak state of the predictor
	cfg_t             soak_cfg;
	logic [TimeW-1:0] run_start_ms;
	logic             run_started;
	logic             allowed_state;
	logic             done_state;
	logic [ZoneW-1:0] prev_zone_mask;

	soak_status_t expected_status_q[$];

	int   error_count;
	int   sample_count;
	int   stall_cycles;
	logic idle_enable;
	logic hold_request;
	int   hold_left;
	logic [ZoneW-1:0] last_zones_sent;

	initial clk = 1'b0;
	always #(CLK_HALF) clk = ~clk;

	// --------------------------------------------------------------------
	// Predictor
	// --------------------------------------------------------------------

	// required soak in ms for a target under the current shadow registers
	function automatic longint soak_required_ms(input logic [TargetW-1:0] target);
		if (target < soak_cfg.min_soak_target)
			return 0;
		return (longint'(soak_cfg.base_soak_s) +
			(longint'(target) - longint'(soak_cfg.min_soak_target)) *
			longint'(soak_cfg.soak_per_degree_s)) * MsPerS;
	endfunction

	function automatic soak_status_t predict_soak_status(input soak_sample_t s);
		int               diff;
		logic             near;
		logic             zones_changed;
		logic [TimeW-1:0] elapsed_raw;
		longint           elapsed;
		longint           left_ms;
		longint           secs;
		soak_status_t     st;
		st = '0;
		// compare in 1/16 degree; target 0 means heater off
		diff = int'(s.bed_temp) - int'(s.target) * 16;
		if (diff < 0)
			diff = -diff;
		near = (s.target != 0) && (diff < int'(soak_cfg.near_window_deg) * 16);
		// the last mask always follows the input, the check only decides the violation
		zones_changed = 1'b0;
		if (s.zones != prev_zone_mask) begin
			prev_zone_mask = s.zones;
			zones_changed = soak_cfg.zone_check_enable;
		end
		if (near && !zones_changed) begin
			if (!run_started) begin
				run_start_ms = s.stamp_ms;
				run_started = 1'b1;
			end
			allowed_state = 1'b1;
			if (!done_state) begin
				// elapsed wraps mod 2^32 and reads as signed: past 2^31 is negative
				elapsed_raw = s.stamp_ms - run_start_ms;
				elapsed = longint'($signed(elapsed_raw));
				left_ms = soak_required_ms(s.target) - elapsed;
				secs = (left_ms > 0) ? left_ms / MsPerS : 0;
				if (secs == 0)
					done_state = 1'b1;
				else
					st.remaining = RemW'((secs > RemMax) ? longint'(RemMax) : secs);
			end
		end else begin
			run_started = 1'b0;
			run_start_ms = '0;
			allowed_state = 1'b0;
			done_state = 1'b0;
		end
		st.allowed = allowed_state;
		st.done = done_state;
		return st;
	endfunction

	// --------------------------------------------------------------------
	// Stimulus helpers
	// --------------------------------------------------------------------

	function automatic soak_sample_t make_sample(input int temp, input int target,
		input logic [ZoneW-1:0] zones, input logic [TimeW-1:0] stamp_ms);
		soak_sample_t s;
		s.bed_temp = TempW'(temp);
		s.target = TargetW'(target);
		s.zones = zones;
		s.stamp_ms = stamp_ms;
		return s;
	endfunction

	// any temperature from -1024 to 4095 (1/16 degree)
	function automatic int far_temp();
		return int'($urandom_range(5119)) - 1024;
	endfunction

	// temperature strictly inside the window, clamped to -1024 .. 4095
	function automatic int near_temp(input int target);
		int span;
		int temp;
		span = (soak_cfg.near_window_deg != 0) ? int'(soak_cfg.near_window_deg) * 16 - 1 : 0;
		temp = target * 16 + int'($urandom_range(2 * span)) - span;
		if (temp > 4095)
			temp = 4095;
		if (temp < -1024)
			temp = -1024;
		return temp;
	endfunction

	// mostly targets that need a soak, some off
	function automatic int pick_target();
		int r;
		int lo;
		r = $urandom_range(99);
		lo = (soak_cfg.min_soak_target != 0) ? int'(soak_cfg.min_soak_target) : 1;
		if (r < 10)
			return 0;
		if (r < 75)
			return int'($urandom_range(255, lo));
		return int'($urandom_range(255, 1));
	endfunction

	// One input transfer; the expectation is queued at the accepting edge.
	// Returns at the falling edge after the transfer with valid still high.
	task automatic send_sample(input soak_sample_t s);
		while (idle_enable && $urandom_range(99) < IDLE_PCT) begin
			sample_ch.valid <= 1'b0;
			@(negedge clk);
		end
		sample_ch.valid       <= 1'b1;
		sample_ch.bed_temp_q4 <= s.bed_temp;
		sample_ch.target_temp <= s.target;
		sample_ch.zone_mask   <= s.zones;
		sample_ch.now_ms      <= s.stamp_ms;
		@(posedge clk);
		while (!sample_ch.ready)
			@(posedge clk);
		expected_status_q.push_back(predict_soak_status(s));
		sample_count++;
		last_zones_sent = s.zones;
		@(negedge clk);
	endtask

	// drop valid, let every result come back and the pipeline go quiet
	task automatic settle();
		sample_ch.valid <= 1'b0;
		while (expected_status_q.size() != 0)
			@(negedge clk);
		repeat (PIPE_SETTLE) @(negedge clk);
	endtask

	task automatic write_register(input logic [CfgIdxW-1:0] idx,
		input logic [CfgDataW-1:0] data);
		write_en   <= 1'b1;
		reg_index  <= idx;
		write_data <= data;
		@(negedge clk);
		write_en <= 1'b0;
		@(negedge clk);
		case (idx)
			REG_NEAR_WINDOW: soak_cfg.near_window_deg = data[WinW-1:0];
			REG_MIN_TARGET:  soak_cfg.min_soak_target = data[MinW-1:0];
			REG_BASE_SOAK:   soak_cfg.base_soak_s = data[BaseW-1:0];
			REG_SOAK_SLOPE:  soak_cfg.soak_per_degree_s = data[SlopeW-1:0];
			REG_ZONE_CHECK:  soak_cfg.zone_check_enable = data[0];
			default: ; // unused index, write has no effect
		endcase
	endtask

	task automatic write_all_registers(input int window, input int min_target,
		input int base_s, input int slope_s, input int zone_check);
		write_register(REG_NEAR_WINDOW, CfgDataW'(window));
		write_register(REG_MIN_TARGET, CfgDataW'(min_target));
		write_register(REG_BASE_SOAK, CfgDataW'(base_s));
		write_register(REG_SOAK_SLOPE, CfgDataW'(slope_s));
		write_register(REG_ZONE_CHECK, CfgDataW'(zone_check));
	endtask

	// A heat-up run at one target: mostly near samples with time moving forward
	// at a pace that spans the required soak, with the odd far sample, zone flip
	// and step back in time.
	task automatic run_soak(input int n, input int target);
		logic [ZoneW-1:0] zones;
		logic [TimeW-1:0] stamp_ms;
		int               step_max;
		int               temp;
		zones = $urandom_range(1) ? last_zones_sent : ZoneW'($urandom);
		stamp_ms = $urandom;
		step_max = int'(soak_required_ms(TargetW'(target)) * 2 / n) + 1500;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(19) == 0)
				zones[$urandom_range(ZoneW - 1)] ^= 1'b1;
			temp = ($urandom_range(99) < 88) ? near_temp(target) : far_temp();
			if ($urandom_range(19) == 0)
				stamp_ms -= $urandom_range(step_max);
			else
				stamp_ms += $urandom_range(step_max);
			send_sample(make_sample(temp, target, zones, stamp_ms));
		end
	endtask

	// --------------------------------------------------------------------
	// Tests
	// --------------------------------------------------------------------

	// Reset registers: window 15, min 60, base 180 s, 14 s/deg, zone check on.
	task automatic test_directed_cases();
		// heater off, then a cold bed at -64 degrees
		send_sample(make_sample(0, 0, 16'h0000, 32'h0000_0000));
		send_sample(make_sample(-1024, 100, 16'h0000, 32'h0000_0001));
		// hottest reading at the top target, then a stamp slightly behind the start
		send_sample(make_sample(4095, 255, 16'h0000, 32'h0000_000A));
		send_sample(make_sample(4095, 255, 16'h0000, 32'hFFFF_FFFF));
		// exactly on the window edge is not near
		send_sample(make_sample(1600 + 240, 100, 16'h0000, 32'h0000_0014));
		// just inside the window, start close to the top of the timestamp range
		send_sample(make_sample(1600 - 239, 100, 16'h0000, 32'hFFFF_FC00));
		// timestamp wraps past zero
		send_sample(make_sample(1600 + 239, 100, 16'h0000, 32'h0000_0200));
		// elapsed reads as -2^31: remainder saturates
		send_sample(make_sample(1600, 100, 16'h0000, 32'h7FFF_FC00));
		// zone mask change breaks the soak, then a fresh start
		send_sample(make_sample(1600, 100, 16'hFFFF, 32'h0000_0300));
		send_sample(make_sample(1600, 100, 16'hFFFF, 32'd1000));
		// one second left, then under one second: done
		send_sample(make_sample(1600, 100, 16'hFFFF, 32'd1000 + 32'd740000 - 32'd1001));
		send_sample(make_sample(1600, 100, 16'hFFFF, 32'd1000 + 32'd740000 - 32'd999));
		// done stays set even with a stamp far behind
		send_sample(make_sample(1600, 100, 16'hFFFF, 32'd5));
		send_sample(make_sample(1600 - 240, 100, 16'hFFFF, 32'd6));
		// below the minimum target: no soak needed
		send_sample(make_sample(640, 40, 16'hFFFF, 32'd7));
		send_sample(make_sample(640, 40, 16'h0001, 32'd8));
		send_sample(make_sample(0, 0, 16'h0001, 32'd9));
		// all-ones temperature (-1/16 degree) against a 1 degree target
		send_sample(make_sample(-1, 1, 16'h5555, 32'd10));
		send_sample(make_sample(-1, 1, 16'h5555, 32'd100));
		send_sample(make_sample(960, 60, 16'hAAAA, 32'd0));
		// target at the minimum: base soak only
		send_sample(make_sample(960, 60, 16'hAAAA, 32'd0));
		send_sample(make_sample(960, 60, 16'hAAAA, 32'd179000));
		send_sample(make_sample(960, 60, 16'hAAAA, 32'd180000));
	endtask

	task automatic test_register_extremes();
		// zero window from a value with only upper bits set: nothing is near
		settle();
		write_register(REG_NEAR_WINDOW, 10'h3C0);
		run_soak(6, 100);
		// widest window, no soak at all
		settle();
		write_all_registers(10'h3FF, 0, 0, 0, 1);
		run_soak(6, pick_target());
		// top minimum and longest base
		settle();
		write_all_registers(63, 255, 1023, 63, 1);
		run_soak(8, 255);
		run_soak(4, 200);
		// longest possible soak: 1023 s + 255 * 63 s
		settle();
		write_register(REG_MIN_TARGET, 0);
		run_soak(8, 255);
		run_soak(6, pick_target());
		// indexes past the last register must not change anything
		settle();
		for (int idx = int'(REG_ZONE_CHECK) + 1; idx < (1 << CfgIdxW); idx++)
			write_register(CfgIdxW'(idx), '1);
		run_soak(6, pick_target());
		settle();
		write_all_registers(NEAR_WINDOW_RST, MIN_TARGET_RST, BASE_SOAK_RST,
			SOAK_SLOPE_RST, ZONE_CHECK_RST);
		run_soak(6, pick_target());
	endtask

	// zones change on every sample and are ignored with the check off, on every third and fatal with it on
	task automatic test_zone_check();
		logic [TimeW-1:0] stamp_ms;
		settle();
		write_register(REG_ZONE_CHECK, 0);
		stamp_ms = $urandom;
		for (int i = 0; i < 10; i++) begin
			stamp_ms += 1000;
			send_sample(make_sample(near_temp(120), 120, ZoneW'($urandom), stamp_ms));
		end
		settle();
		write_register(REG_ZONE_CHECK, 1);
		for (int i = 0; i < 10; i++) begin
			stamp_ms += 1000;
			send_sample(make_sample(near_temp(120), 120,
				(i % 3 == 0) ? ZoneW'($urandom) : last_zones_sent, stamp_ms));
		end
	endtask

	// results held off long enough that the pipeline fills and input stalls
	task automatic test_output_stall();
		settle();
		idle_enable = 1'b0;
		hold_request = 1'b1;
		run_soak(30, pick_target());
		idle_enable = 1'b1;
	endtask

	task automatic test_random_soak();
		int first_count;
		int next_cfg_at;
		first_count = sample_count;
		next_cfg_at = sample_count;
		while (sample_count < ITEM_GOAL) begin
			if (sample_count >= next_cfg_at) begin
				settle();
				if ($urandom_range(3) == 0)
					write_all_registers(NEAR_WINDOW_RST, MIN_TARGET_RST, BASE_SOAK_RST,
						SOAK_SLOPE_RST, ZONE_CHECK_RST);
				else
					// short soaks so that runs reach done often
					write_all_registers($urandom_range(63, 1), $urandom_range(255),
						$urandom_range(40), $urandom_range(4), $urandom_range(1));
				next_cfg_at = sample_count + int'($urandom_range(90, 60));
			end
			// one long stretch with no idling on either side
			idle_enable = !((sample_count >= first_count + 200) &&
				(sample_count < first_count + 320));
			if ($urandom_range(99) < 15)
				send_sample(make_sample(far_temp(), $urandom_range(255), ZoneW'($urandom),
					$urandom));
			else
				run_soak($urandom_range(25, 3), pick_target());
		end
		idle_enable = 1'b1;
	endtask

	// --------------------------------------------------------------------
	// Result side: ready driver, checker, watchdog
	// --------------------------------------------------------------------

	// ready changes on the falling edge; a hold request starts a counted stall
	initial begin
		result_ch.ready = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				result_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				result_ch.ready <= !(idle_enable && $urandom_range(99) < IDLE_PCT);
			end
		end
	end

	task automatic check_field(input string name, input longint expected_v,
		input longint actual_v);
		if (expected_v != actual_v) begin
			error_count++;
			$display("%0t: %s mismatch, expected %0d actual %0d", $time, name,
				expected_v, actual_v);
		end
	endtask

	always @(posedge clk) begin
		soak_status_t exp_status;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (expected_status_q.size() == 0) begin
				error_count++;
				$display("%0t: result transfer with nothing expected, actual %0d %0d %0d",
					$time, result_ch.soak_allowed, result_ch.soak_done, result_ch.secs_left);
			end else begin
				exp_status = expected_status_q.pop_front();
				check_field("soak_allowed", exp_status.allowed, result_ch.soak_allowed);
				check_field("soak_done", exp_status.done, result_ch.soak_done);
				check_field("secs_left", exp_status.remaining, result_ch.secs_left);
			end
		end
	end

	always @(posedge clk) begin
		if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("%0t: no transfer for %0d cycles, %0d results outstanding",
				$time, stall_cycles, expected_status_q.size());
			$display("status: fail");
			$finish;
		end
	end

	// --------------------------------------------------------------------
	// Main sequence
	// --------------------------------------------------------------------

	initial begin
		arst_n = 1'b0;
		write_en = 1'b0;
		reg_index = '0;
		write_data = '0;
		sample_ch.valid = 1'b0;
		sample_ch.bed_temp_q4 = '0;
		sample_ch.target_temp = '0;
		sample_ch.zone_mask = '0;
		sample_ch.now_ms = '0;
		error_count = 0;
		sample_count = 0;
		stall_cycles = 0;
		idle_enable = 1'b1;
		hold_request = 1'b0;
		last_zones_sent = '0;
		soak_cfg.near_window_deg = NEAR_WINDOW_RST;
		soak_cfg.min_soak_target = MIN_TARGET_RST;
		soak_cfg.base_soak_s = BASE_SOAK_RST;
		soak_cfg.soak_per_degree_s = SOAK_SLOPE_RST;
		soak_cfg.zone_check_enable = ZONE_CHECK_RST;
		run_start_ms = '0;
		run_started = 1'b0;
		allowed_state = 1'b0;
		done_state = 1'b0;
		prev_zone_mask = '0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n = 1'b1;

		test_directed_cases();
		test_register_extremes();
		test_zone_check();
		test_output_stall();
		test_random_soak();

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
